@@ src/encoder_window_speed_meter_assert.svh @@
// ----------------------------------------------------------------------------
// Encoder window speed meter assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_WINDOW_SPEED_METER_ASSERT_SVH
`define ENCODER_WINDOW_SPEED_METER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EWSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ewsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder window speed meter package
// Item types, register map, direction codes and shared constants.
// ----------------------------------------------------------------------------
package ewsm_pkg;

  localparam int unsigned WINDOW_DEFAULT = 16;
  localparam int unsigned COUNTS_PER_REV = 2048;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned RUN_W   = 16;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned PROD_W  = SUM_W + GAIN_W;
  localparam int unsigned PADDR_W = 4;

  localparam logic [COUNT_W-1:0] REV_MOD = COUNT_W'(COUNTS_PER_REV);

  localparam logic [1:0] CMD_CW  = 2'd0;
  localparam logic [1:0] CMD_CCW = 2'd1;

  localparam logic [1:0] REG_SPEED_GAIN = 2'd0;
  localparam logic [1:0] REG_RPM_GAIN   = 2'd1;
  localparam logic [1:0] REG_ERR_LIMIT  = 2'd2;
  localparam logic [1:0] REG_NEAR_STOP  = 2'd3;

  localparam logic [GAIN_W-1:0]  SPEED_GAIN_RST = 32'd65536;
  localparam logic [GAIN_W-1:0]  RPM_GAIN_RST   = 32'd65536;
  localparam logic [RUN_W-1:0]   ERR_LIMIT_RST  = 16'd200;
  localparam logic [SUM_W-1:0]   NEAR_STOP_RST  = 15'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] encoder_count;
    logic               counting_down;
    logic [1:0]         commanded_direction;
  } ewsm_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_delta;
    logic [SUM_W-1:0]   window_sum;
    logic [14:0]        speed_scaled;
    logic [15:0]        speed_rpm;
    logic               zero_speed;
    logic               direction_fault;
  } ewsm_out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_delta;
    logic [SUM_W-1:0]   window_sum;
    logic               direction_fault;
  } ewsm_side_t;

endpackage

@@ src/ewsm_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder window speed meter scaling stage
// Multiplies the window sum by both Q16.16 gains and saturates the results.
// ----------------------------------------------------------------------------
module ewsm_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  ewsm_pkg::ewsm_side_t                side_i,
  input  logic [ewsm_pkg::GAIN_W-1:0]         speed_gain_i,
  input  logic [ewsm_pkg::GAIN_W-1:0]         rpm_gain_i,
  output logic                                valid_o,
  output ewsm_pkg::ewsm_out_t                 result_o
);
  import ewsm_pkg::*;

  logic                  valid_q;
  ewsm_side_t            side_q;
  logic [PROD_W-1:0]     prod_speed_q;
  logic [PROD_W-1:0]     prod_rpm_q;
  logic [PROD_W-17:0]    speed_sh;
  logic [PROD_W-17:0]    rpm_sh;
  logic [15:0]           rpm_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q       <= side_i;
      prod_speed_q <= PROD_W'(side_i.window_sum) * PROD_W'(speed_gain_i);
      prod_rpm_q   <= PROD_W'(side_i.window_sum) * PROD_W'(rpm_gain_i);
    end
  end

  always_comb begin
    speed_sh = prod_speed_q[PROD_W-1:16];
    rpm_sh   = prod_rpm_q[PROD_W-1:16];
    rpm_sat  = (|rpm_sh[PROD_W-17:16]) ? 16'hFFFF : rpm_sh[15:0];
    result_o.count_delta     = side_q.count_delta;
    result_o.window_sum      = side_q.window_sum;
    result_o.speed_scaled    = (|speed_sh[PROD_W-17:15]) ? 15'h7FFF : speed_sh[14:0];
    result_o.speed_rpm       = rpm_sat;
    result_o.zero_speed      = (rpm_sat < 16'd2);
    result_o.direction_fault = side_q.direction_fault;
  end

  assign valid_o = valid_q;

endmodule

@@ src/encoder_window_speed_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder window speed meter
// Moving-window speed and RPM from a quadrature encoder counter sampled on
// periodic ticks, with wrong-direction supervision and a sticky fault flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_data_i  (ewsm_in_t)
// out       output     out_valid_o/out_ready_i out_data_o (ewsm_out_t)
// cfg       input      psel/penable/pwrite    paddr, pwdata, prdata
//
// One item is accepted per cycle unless the output stalls.
// The delta ring sits in a one-port-write, one-port-read memory whose next
// entry is prefetched for the tick-to-tick state loop.
// Reset clears the ring through per-entry valid bits; no clearing pass runs.
// A stalled output holds the whole pipeline, and input ready drops with it.
// ----------------------------------------------------------------------------
module encoder_window_speed_meter #(
  parameter int unsigned WINDOW = ewsm_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ewsm_pkg::ewsm_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ewsm_pkg::ewsm_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ewsm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ewsm_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  logic [GAIN_W-1:0]  speed_gain_q;
  logic [GAIN_W-1:0]  rpm_gain_q;
  logic [RUN_W-1:0]   err_limit_q;
  logic [SUM_W-1:0]   near_stop_q;

  logic [COUNT_W-1:0] last_count_q;
  logic [COUNT_W-1:0] held_q, held_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [RUN_W-1:0]   cw_run_q, cw_run_d;
  logic [RUN_W-1:0]   ccw_run_q, ccw_run_d;
  logic               fault_q, fault_d;
  logic [WINDOW-1:0]  ring_valid_q;

  logic [COUNT_W-1:0] ring_mem [WINDOW];
  logic [COUNT_W-1:0] ring_rd_q;
  logic [COUNT_W-1:0] oldest;

  logic               adv;
  logic               accept;
  logic               cfg_write;
  logic [COUNT_W-1:0] cw_dist, ccw_dist;

  logic               s1_valid_q;
  ewsm_side_t         s1_side_q;
  logic               s2_valid;
  ewsm_out_t          s2_result;
  logic               out_valid_q;
  ewsm_out_t          out_data_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign cfg_write  = psel && penable && pwrite;
  assign pready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_gain_q <= SPEED_GAIN_RST;
      rpm_gain_q   <= RPM_GAIN_RST;
      err_limit_q  <= ERR_LIMIT_RST;
      near_stop_q  <= NEAR_STOP_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SPEED_GAIN: speed_gain_q <= pwdata;
        REG_RPM_GAIN:   rpm_gain_q   <= pwdata;
        REG_ERR_LIMIT:  err_limit_q  <= pwdata[RUN_W-1:0];
        REG_NEAR_STOP:  near_stop_q  <= pwdata[SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SPEED_GAIN: prdata = speed_gain_q;
      REG_RPM_GAIN:   prdata = rpm_gain_q;
      REG_ERR_LIMIT:  prdata = 32'(err_limit_q);
      REG_NEAR_STOP:  prdata = 32'(near_stop_q);
      default:        prdata = 32'd0;
    endcase
  end

  always_comb begin
    cw_dist  = (in_data_i.encoder_count - last_count_q)
             + ((in_data_i.encoder_count < last_count_q) ? REV_MOD : '0);
    ccw_dist = (last_count_q - in_data_i.encoder_count)
             + ((last_count_q < in_data_i.encoder_count) ? REV_MOD : '0);
    held_d    = held_q;
    cw_run_d  = cw_run_q;
    ccw_run_d = ccw_run_q;
    case (in_data_i.commanded_direction)
      CMD_CW: begin
        if (!in_data_i.counting_down) begin
          held_d   = cw_dist;
          cw_run_d = '0;
        end else begin
          cw_run_d = (&cw_run_q) ? cw_run_q : cw_run_q + 1'b1;
          if (sum_q <= near_stop_q) begin
            held_d = '0;
          end
        end
      end
      CMD_CCW: begin
        if (in_data_i.counting_down) begin
          held_d    = ccw_dist;
          ccw_run_d = '0;
        end else begin
          ccw_run_d = (&ccw_run_q) ? ccw_run_q : ccw_run_q + 1'b1;
          if (sum_q <= near_stop_q) begin
            held_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
    fault_d = fault_q || (cw_run_d >= err_limit_q) || (ccw_run_d >= err_limit_q);
    oldest  = ring_valid_q[pos_q] ? ring_rd_q : '0;
    sum_d   = sum_q - SUM_W'(oldest) + SUM_W'(held_d);
    pos_d   = pos_q;
    if (accept) begin
      pos_d = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[pos_q] <= held_d;
    end
    ring_rd_q <= ring_mem[pos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      held_q       <= '0;
      pos_q        <= '0;
      sum_q        <= '0;
      cw_run_q     <= '0;
      ccw_run_q    <= '0;
      fault_q      <= 1'b0;
      ring_valid_q <= '0;
    end else if (accept) begin
      last_count_q        <= in_data_i.encoder_count;
      held_q              <= held_d;
      pos_q               <= pos_d;
      sum_q               <= sum_d;
      cw_run_q            <= cw_run_d;
      ccw_run_q           <= ccw_run_d;
      fault_q             <= fault_d;
      ring_valid_q[pos_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept;
      out_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q.count_delta     <= held_d;
      s1_side_q.window_sum      <= sum_d;
      s1_side_q.direction_fault <= fault_d;
      out_data_q                <= s2_result;
    end
  end

  ewsm_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (s1_valid_q),
    .side_i       (s1_side_q),
    .speed_gain_i (speed_gain_q),
    .rpm_gain_i   (rpm_gain_q),
    .valid_o      (s2_valid),
    .result_o     (s2_result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "encoder_window_speed_meter_assert.svh"

  `EWSM_ASSERT_SAME(a_stall_blocks_input, out_valid_q && !out_ready_i, !in_ready_o, "input taken during output stall")
  `EWSM_ASSERT_NEXT(a_fault_sticky, fault_q, fault_q, "direction fault cleared")
  `EWSM_ASSERT_SAME(a_zero_speed_match, out_valid_q, out_data_q.zero_speed == (out_data_q.speed_rpm < 16'd2), "zero speed flag mismatch")
  `EWSM_ASSERT_NEXT(a_idle_keeps_delta, accept && in_data_i.commanded_direction != CMD_CW && in_data_i.commanded_direction != CMD_CCW, s1_side_q.count_delta == $past(held_q), "idle command changed delta")

endmodule
